### src/uwf_pkg.sv
package uwf_pkg;

    // Frame phases shared by the transmit and receive engines.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_PARITY = 3'd3,
        PH_STOP   = 3'd4
    } phase_t;

    // Baud ticks from the half-bit scaler.
    typedef struct packed {
        logic rise;
        logic fall;
    } baud_tick_t;

    // FIFO and engine status seen by the register map.
    typedef struct packed {
        logic full;
        logic empty;
        logic idle;
    } fifo_status_t;

    // Bit positions in the transmit and receive mode registers.
    localparam int MODE_EN       = 0;
    localparam int MODE_TWO_STOP = 1;
    localparam int MODE_PARITY   = 2;

    // Frame geometry.
    localparam int DATA_BITS = 8;
    localparam int FRAME_W   = 11;
    localparam logic [3:0] TX_LAST_DATA = 4'd8;
    localparam logic [3:0] RX_LAST_DATA = 4'd7;
    localparam logic [FRAME_W-1:0] FRAME_IDLE = '1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HALF_BIT  = 3'd0;
    localparam logic [2:0] CFG_TX_MODE   = 3'd1;
    localparam logic [2:0] CFG_RX_MODE   = 3'd2;
    localparam logic [2:0] CFG_TX_THRESH = 3'd3;
    localparam logic [2:0] CFG_RX_THRESH = 3'd4;
    localparam logic [2:0] CFG_IRQ_EN    = 3'd5;
    localparam logic [2:0] CFG_CPU_ID    = 3'd6;

    // Bus register map word indexes.
    localparam logic [9:0] REG_TX_DATA  = 10'd0;
    localparam logic [9:0] REG_RX_DATA  = 10'd1;
    localparam logic [9:0] REG_TX_CTRL  = 10'd2;
    localparam logic [9:0] REG_RX_CTRL  = 10'd3;
    localparam logic [9:0] REG_IRQ_EN   = 10'd4;
    localparam logic [9:0] REG_IRQ_PEND = 10'd5;
    localparam logic [9:0] REG_SCALER   = 10'd6;
    localparam logic [9:0] REG_ID       = 10'd7;

    // Bus access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Even parity of one data byte.
    function automatic logic parity8(input logic [DATA_BITS-1:0] value);
        return ^value;
    endfunction

endpackage

### src/uwf_baud.sv
module uwf_baud (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [31:0]        half_bit_cycles,
    input  logic               hold,
    output uwf_pkg::baud_tick_t tick
);
    import uwf_pkg::*;

    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        level_reg;
    logic        level_next;
    logic        wrap;

    // Half-bit counter; a wrap toggles the baud level.
    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        wrap       = 1'b0;
        if (half_bit_cycles != 32'd0)
        begin
            wrap = (count_reg == 32'(half_bit_cycles - 32'd1));
            if (wrap)
            begin
                count_next = 32'd0;
                level_next = ~level_reg;
            end
            else
            begin
                count_next = 32'(count_reg + 32'd1);
            end
            // Both engines idle on a high line: park the scaler.
            if (hold)
            begin
                count_next = 32'd0;
                level_next = 1'b1;
            end
        end
    end

    assign tick.rise = wrap && !level_reg;
    assign tick.fall = wrap && level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 32'd0;
            level_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

### src/uwf_tx.sv
module uwf_tx #(
    parameter int ADDR_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  rise,
    input  logic [2:0]            mode,
    input  logic                  push,
    input  logic [7:0]            push_data,
    output logic                  line_next,
    output uwf_pkg::fifo_status_t status,
    output logic [ADDR_BITS-1:0]  level
);
    import uwf_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] PTR_ONE = ADDR_BITS'(1);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] head_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [FRAME_W-1:0]   shifter_reg;
    logic [FRAME_W-1:0]   shifter_next;
    logic [3:0]           bit_count_reg;
    logic [3:0]           bit_count_next;
    logic                 stop_left_reg;
    logic                 stop_left_next;
    logic [ADDR_BITS-1:0] rd_ptr_reg;
    logic [ADDR_BITS-1:0] rd_ptr_next;
    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [ADDR_BITS-1:0] wr_ptr_next;
    logic [ADDR_BITS-1:0] wr_inc;
    logic [ADDR_BITS-1:0] rd_inc;

    // FIFO status from the pointers; one slot stays unused.
    assign wr_inc       = wr_ptr_reg + PTR_ONE;
    assign rd_inc       = rd_ptr_reg + PTR_ONE;
    assign status.full  = (wr_inc == rd_ptr_reg);
    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.idle  = (phase_reg == PH_IDLE);
    assign level        = wr_ptr_reg - rd_ptr_reg;
    assign line_next    = shifter_next[0];

    // Frame sequencer, advanced on rising baud ticks.
    always_comb
    begin
        phase_next     = phase_reg;
        shifter_next   = shifter_reg;
        bit_count_next = bit_count_reg;
        stop_left_next = stop_left_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = push ? wr_inc : wr_ptr_reg;
        if (step && rise)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!status.empty && mode[MODE_EN])
                    begin
                        if (mode[MODE_PARITY])
                            shifter_next = {1'b1, parity8(head_reg), head_reg, 1'b0};
                        else
                            shifter_next = {2'b11, head_reg, 1'b0};
                        phase_next     = PH_START;
                        rd_ptr_next    = rd_inc;
                        bit_count_next = 4'd0;
                    end
                    else
                    begin
                        shifter_next = FRAME_IDLE;
                    end
                end
                PH_START:
                begin
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (bit_count_reg == TX_LAST_DATA)
                    begin
                        phase_next     = mode[MODE_PARITY] ? PH_PARITY : PH_STOP;
                        stop_left_next = mode[MODE_TWO_STOP];
                    end
                end
                PH_PARITY:
                begin
                    phase_next     = PH_STOP;
                    stop_left_next = mode[MODE_TWO_STOP];
                end
                PH_STOP:
                begin
                    if (!stop_left_reg)
                        phase_next = PH_IDLE;
                    else
                        stop_left_next = 1'b0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            // Shift the frame out one bit, filling with the idle level.
            if (phase_reg != PH_IDLE)
            begin
                bit_count_next = bit_count_reg + 4'd1;
                shifter_next   = {1'b1, shifter_reg[FRAME_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shifter_reg   <= '0;
            bit_count_reg <= 4'd0;
            stop_left_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shifter_reg   <= shifter_next;
            bit_count_reg <= bit_count_next;
            stop_left_reg <= stop_left_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
        end
    end

    // Queue storage with a registered head; a write into the head slot bypasses.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
        if (push && (wr_ptr_reg == rd_ptr_next))
            head_reg <= push_data;
        else
            head_reg <= mem_reg[rd_ptr_next];
    end

endmodule

### src/uwf_rx.sv
module uwf_rx #(
    parameter int ADDR_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  fall,
    input  logic                  rx_line,
    input  logic [2:0]            mode,
    input  logic                  pop,
    output logic [7:0]            head,
    output logic [1:0]            err_next,
    output uwf_pkg::fifo_status_t status,
    output logic [ADDR_BITS-1:0]  level
);
    import uwf_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] PTR_ONE = ADDR_BITS'(1);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] head_reg;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [DATA_BITS-1:0] shifter_reg;
    logic [DATA_BITS-1:0] shifter_next;
    logic [3:0]           bit_count_reg;
    logic [3:0]           bit_count_next;
    logic                 stop_left_reg;
    logic                 stop_left_next;
    logic [1:0]           err_reg;
    logic [ADDR_BITS-1:0] rd_ptr_reg;
    logic [ADDR_BITS-1:0] rd_ptr_next;
    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [ADDR_BITS-1:0] wr_ptr_next;
    logic [ADDR_BITS-1:0] wr_inc;
    logic [ADDR_BITS-1:0] rd_inc;
    logic                 push;

    assign wr_inc       = wr_ptr_reg + PTR_ONE;
    assign rd_inc       = rd_ptr_reg + PTR_ONE;
    assign status.full  = (wr_inc == rd_ptr_reg);
    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.idle  = (phase_reg == PH_IDLE);
    assign level        = wr_ptr_reg - rd_ptr_reg;
    assign head         = head_reg;

    // Receive sequencer, sampling the line on falling baud ticks.
    always_comb
    begin
        phase_next     = phase_reg;
        shifter_next   = shifter_reg;
        bit_count_next = bit_count_reg;
        stop_left_next = stop_left_reg;
        err_next       = err_reg;
        push           = 1'b0;
        if (step && fall)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!rx_line && mode[MODE_EN])
                    begin
                        phase_next     = PH_DATA;
                        shifter_next   = '0;
                        bit_count_next = 4'd0;
                    end
                end
                PH_DATA:
                begin
                    shifter_next = {rx_line, shifter_reg[DATA_BITS-1:1]};
                    if (bit_count_reg == RX_LAST_DATA)
                    begin
                        phase_next     = mode[MODE_PARITY] ? PH_PARITY : PH_STOP;
                        stop_left_next = mode[MODE_TWO_STOP];
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 4'd1;
                    end
                end
                PH_PARITY:
                begin
                    err_next[0]    = (parity8(shifter_reg) != rx_line);
                    phase_next     = PH_STOP;
                    stop_left_next = mode[MODE_TWO_STOP];
                end
                PH_STOP:
                begin
                    err_next[1] = !rx_line;
                    if (!stop_left_reg)
                    begin
                        // A frame that finds the queue full is dropped.
                        push       = !status.full;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        stop_left_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        wr_ptr_next = push ? wr_inc : wr_ptr_reg;
        rd_ptr_next = pop ? rd_inc : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shifter_reg   <= '0;
            bit_count_reg <= 4'd0;
            stop_left_reg <= 1'b0;
            err_reg       <= 2'd0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shifter_reg   <= shifter_next;
            bit_count_reg <= bit_count_next;
            stop_left_reg <= stop_left_next;
            err_reg       <= err_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
        end
    end

    // Queue storage with a registered head; a write into the head slot bypasses.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= shifter_reg;
        if (push && (wr_ptr_reg == rd_ptr_next))
            head_reg <= shifter_reg;
        else
            head_reg <= mem_reg[rd_ptr_next];
    end

endmodule

### src/uart_with_fifos_and_register_map.sv
// Channel  | Handshake                    | Payload
// input    | in_valid / in_stall          | rx_line, req_valid, cmd, reg_index, write_data
// output   | out_valid / out_stall        | bus_ack, read_data, tx_line, parity_error,
//          |                              | stop_error
// config   | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// Each item is one tick. Its result item passes through the input register and the
// result register to the output, and is held back while the output is stalled.
// One item per cycle is sustained while the output is not stalled; the input register,
// one pass of the engines and register map, and the result register carry each item.
// Reset clears all control state; the queues need no clearing pass.
// A stalled output holds its result, and the input stalls only while the input
// register holds an item and the output register is full and stalled.
module uart_with_fifos_and_register_map #(
    parameter int FIFO_ADDR_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        rx_line,
    input  logic        req_valid,
    input  logic        cmd,
    input  logic [9:0]  reg_index,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        bus_ack,
    output logic [31:0] read_data,
    output logic        tx_line,
    output logic        parity_error,
    output logic        stop_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import uwf_pkg::*;

    localparam int CMP_W = (FIFO_ADDR_BITS > 4) ? FIFO_ADDR_BITS : 4;
    localparam logic [CMP_W-1:0] LEVEL_MASK = CMP_W'((1 << FIFO_ADDR_BITS) - 1);

    // Configuration registers.
    logic [31:0] half_bit_cycles_reg;
    logic [2:0]  tx_mode_reg;
    logic [2:0]  rx_mode_reg;
    logic [3:0]  tx_thresh_reg;
    logic [3:0]  rx_thresh_reg;
    logic [1:0]  irq_en_reg;
    logic [31:0] cpu_id_reg;

    // Input register.
    logic        in_valid_reg;
    logic        rx_line_reg;
    logic        req_valid_reg;
    logic        cmd_reg;
    logic [9:0]  reg_index_reg;
    logic [7:0]  write_data_reg;

    // Result register.
    logic        out_valid_reg;
    logic        bus_ack_reg;
    logic [31:0] read_data_reg;
    logic        tx_line_reg;
    logic        parity_error_reg;
    logic        stop_error_reg;

    // Register map state.
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic        guard_reg;
    logic        guard_next;

    logic                      out_free;
    logic                      step;
    logic                      hold;
    logic                      tx_push;
    logic                      rx_pop;
    logic                      tx_line_next;
    logic [1:0]                err_next;
    logic [7:0]                rx_head;
    logic [31:0]               rdata;
    logic [FIFO_ADDR_BITS-1:0] tx_level;
    logic [FIFO_ADDR_BITS-1:0] rx_level;
    baud_tick_t                tick;
    fifo_status_t              tx_status;
    fifo_status_t              rx_status;

    // Pipeline control: the tick is worked when the result register can take it.
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign bus_ack      = bus_ack_reg;
    assign read_data    = read_data_reg;
    assign tx_line      = tx_line_reg;
    assign parity_error = parity_error_reg;
    assign stop_error   = stop_error_reg;

    assign hold = tx_status.idle && rx_status.idle && rx_line_reg;

    uwf_baud u_baud (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .half_bit_cycles (half_bit_cycles_reg),
        .hold            (hold),
        .tick            (tick)
    );

    uwf_tx #(
        .ADDR_BITS (FIFO_ADDR_BITS)
    ) u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rise      (tick.rise),
        .mode      (tx_mode_reg),
        .push      (tx_push),
        .push_data (write_data_reg),
        .line_next (tx_line_next),
        .status    (tx_status),
        .level     (tx_level)
    );

    uwf_rx #(
        .ADDR_BITS (FIFO_ADDR_BITS)
    ) u_rx (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .fall     (tick.fall),
        .rx_line  (rx_line_reg),
        .mode     (rx_mode_reg),
        .pop      (rx_pop),
        .head     (rx_head),
        .err_next (err_next),
        .status   (rx_status),
        .level    (rx_level)
    );

    // Register map decode: read word, queue push and pop, and the full-write guard.
    always_comb
    begin
        rdata      = 32'd0;
        tx_push    = 1'b0;
        rx_pop     = 1'b0;
        guard_next = guard_reg;
        case (reg_index_reg)
            REG_TX_DATA:
            begin
                rdata = {tx_status.full, 31'd0};
                if (req_valid_reg)
                begin
                    if ((cmd_reg == CMD_WRITE) && !tx_status.full && !guard_reg)
                        tx_push = step;
                    else
                        guard_next = tx_status.full;
                end
            end
            REG_RX_DATA:
            begin
                if (rx_status.empty)
                begin
                    rdata = {1'b1, 31'd0};
                end
                else
                begin
                    rdata  = {24'd0, rx_head};
                    rx_pop = step && req_valid_reg && (cmd_reg == CMD_READ);
                end
            end
            REG_TX_CTRL:  rdata = {13'd0, tx_thresh_reg[2:0], 13'd0, tx_mode_reg};
            REG_RX_CTRL:  rdata = {13'd0, rx_thresh_reg[2:0], 13'd0, rx_mode_reg};
            REG_IRQ_EN:   rdata = {30'd0, irq_en_reg};
            REG_IRQ_PEND: rdata = {30'd0, pending_reg};
            REG_SCALER:   rdata = half_bit_cycles_reg;
            REG_ID:       rdata = cpu_id_reg;
            default:      rdata = 32'd0;
        endcase
    end

    // Pending bits take the enable when TX level < or RX level > threshold, else hold.
    always_comb
    begin
        pending_next = pending_reg;
        if (CMP_W'(tx_level) < (CMP_W'(tx_thresh_reg) & LEVEL_MASK))
            pending_next[0] = irq_en_reg[0];
        if (CMP_W'(rx_level) > (CMP_W'(rx_thresh_reg) & LEVEL_MASK))
            pending_next[1] = irq_en_reg[1];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_cycles_reg <= 32'd0;
            tx_mode_reg         <= 3'd0;
            rx_mode_reg         <= 3'd0;
            tx_thresh_reg       <= 4'd0;
            rx_thresh_reg       <= 4'd0;
            irq_en_reg          <= 2'd0;
            cpu_id_reg          <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_BIT:  half_bit_cycles_reg <= cfg_data;
                CFG_TX_MODE:   tx_mode_reg         <= cfg_data[2:0];
                CFG_RX_MODE:   rx_mode_reg         <= cfg_data[2:0];
                CFG_TX_THRESH: tx_thresh_reg       <= cfg_data[3:0];
                CFG_RX_THRESH: rx_thresh_reg       <= cfg_data[3:0];
                CFG_IRQ_EN:    irq_en_reg          <= cfg_data[1:0];
                CFG_CPU_ID:    cpu_id_reg          <= cfg_data;
                default:       cpu_id_reg          <= cpu_id_reg;
            endcase
        end
    end

    // Control state of the pipeline and the register map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 2'd0;
            guard_reg     <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (step)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= pending_next;
                guard_reg     <= guard_next;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input item capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rx_line_reg    <= rx_line;
            req_valid_reg  <= req_valid;
            cmd_reg        <= cmd;
            reg_index_reg  <= reg_index;
            write_data_reg <= write_data;
        end
    end

    // Result item capture.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            bus_ack_reg      <= req_valid_reg;
            read_data_reg    <= req_valid_reg ? rdata : 32'd0;
            tx_line_reg      <= tx_line_next;
            parity_error_reg <= err_next[0];
            stop_error_reg   <= err_next[1];
        end
    end

endmodule

### src/uwf_checker.sv
module uwf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        bus_ack,
    input logic [31:0] read_data,
    input logic        tx_line
);

    // The input only stalls behind a full, stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output could move");

    // An accepted item reaches the output once the output side is not stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted item did not reach the output");

    // A tick without a bus access returns a zero read word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bus_ack) |-> (read_data == 32'd0))
        else $error("read data present without a bus access");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(read_data) && $stable(tx_line)))
        else $error("stalled result changed");

endmodule

bind uart_with_fifos_and_register_map uwf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bus_ack    (bus_ack),
    .read_data  (read_data),
    .tx_line    (tx_line)
);
